/* sv/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants, command codes and payload types of the box collision
// scanner.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int MAX_BOXES  = 8;
  localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int FUNC_W     = 2;
  localparam int SLOT_W     = 3;
  localparam int LAYER_W    = 3;
  localparam int COORD_W    = 16;
  localparam int EXT_W      = 15;
  localparam int CMDQ_DEPTH = 4;

  // item function codes, also used as command codes behind the front end
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd2;

  localparam logic [LAYER_W-1:0] LAYER_NONE = 3'd0;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [SLOT_W-1:0]         slot;
    logic                      enable_bit;
    logic [LAYER_W-1:0]        source_layer;
    logic [LAYER_W-1:0]        target_layer;
    logic                      handler_present;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic [EXT_W-1:0]          extent_x;
    logic [EXT_W-1:0]          extent_y;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] src_index;
    logic [SLOT_W-1:0] dst_index;
    logic              notify_target;
    logic              notify_source;
    logic              scan_done;
  } out_item_t;

  typedef struct packed {
    logic                      enabled;
    logic [LAYER_W-1:0]        src_layer;
    logic [LAYER_W-1:0]        tgt_layer;
    logic                      handler;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [EXT_W-1:0]          w;
    logic [EXT_W-1:0]          h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [IDX_W-1:0]  slot;
    box_t              box;
  } cmd_t;

endpackage

/* sv/aabb_ram.sv */
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module aabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/aabb_front.sv */
// ----------------------------------------------------------------------------
// aabb_front
// Takes items from the command port, drops those that do nothing and turns
// the rest into commands for the queue.
// ----------------------------------------------------------------------------
module aabb_front (
  input  logic              start,
  output logic              busy,
  input  aabb_pkg::in_item_t item,
  input  logic              q_full,
  output logic              push,
  output aabb_pkg::cmd_t    push_cmd
);

  logic accept;
  logic slot_ok;
  logic keep;

  assign busy    = q_full;
  assign accept  = start && !q_full;
  assign slot_ok = {1'b0, item.slot} < (aabb_pkg::SLOT_W + 1)'(aabb_pkg::MAX_BOXES);

  always_comb begin
    case (item.func)
      aabb_pkg::FUNC_WRITE, aabb_pkg::FUNC_REMOVE: begin
        keep = slot_ok;
      end
      aabb_pkg::FUNC_SCAN: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    push_cmd.op            = item.func;
    push_cmd.slot          = item.slot[aabb_pkg::IDX_W-1:0];
    push_cmd.box.enabled   = item.enable_bit;
    push_cmd.box.src_layer = item.source_layer;
    push_cmd.box.tgt_layer = item.target_layer;
    push_cmd.box.handler   = item.handler_present;
    push_cmd.box.cx        = item.centre_x;
    push_cmd.box.cy        = item.centre_y;
    push_cmd.box.w         = item.extent_x;
    push_cmd.box.h         = item.extent_y;
  end

endmodule

/* sv/aabb_cmdq.sv */
// ----------------------------------------------------------------------------
// aabb_cmdq
// Short command queue between the front end and the scan engine.
// ----------------------------------------------------------------------------
module aabb_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aabb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output aabb_pkg::cmd_t q_cmd
);

  localparam int PTR_W = (aabb_pkg::CMDQ_DEPTH > 1) ? $clog2(aabb_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(aabb_pkg::CMDQ_DEPTH + 1);

  aabb_pkg::cmd_t entries [aabb_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(aabb_pkg::CMDQ_DEPTH);
  assign q_valid = count != '0;
  assign q_cmd   = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(aabb_pkg::CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // the front end must never offer a command to a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into full queue");

endmodule

/* sv/aabb_back.sv */
// ----------------------------------------------------------------------------
// aabb_back
// Scan engine: holds the box table, applies writes and removes, and walks
// all ordered slot pairs through a short compare pipeline.
// ----------------------------------------------------------------------------
module aabb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  aabb_pkg::cmd_t      q_cmd,
  output logic                pop,
  output logic                strobe,
  output aabb_pkg::out_item_t result
);

  localparam int IW = aabb_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(aabb_pkg::MAX_BOXES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [IW-1:0]                 src_idx;
  logic [IW-1:0]                 src_idx_next;
  logic [IW-1:0]                 dst_idx;
  logic [IW-1:0]                 dst_idx_next;
  logic [aabb_pkg::MAX_BOXES-1:0] slot_valid;
  logic [aabb_pkg::MAX_BOXES-1:0] slot_valid_next;
  logic                          ram_we;
  logic                          issue_pair;
  logic                          issue_done;

  // compare stage
  logic          b_valid;
  logic          b_done;
  logic [IW-1:0] b_src;
  logic [IW-1:0] b_dst;
  aabb_pkg::box_t src_box;
  aabb_pkg::box_t dst_box;
  logic          hit;

  aabb_ram #(.WIDTH(aabb_pkg::BOX_W), .DEPTH(aabb_pkg::MAX_BOXES)) u_src_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (q_cmd.slot),
    .wr_data (q_cmd.box),
    .rd_addr (src_idx),
    .rd_data (src_box)
  );

  aabb_ram #(.WIDTH(aabb_pkg::BOX_W), .DEPTH(aabb_pkg::MAX_BOXES)) u_dst_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (q_cmd.slot),
    .wr_data (q_cmd.box),
    .rd_addr (dst_idx),
    .rd_data (dst_box)
  );

  // doubled-centre test reduces to 2|c1 - c2| <= e1 + e2
  function automatic logic axis_hit(
    input logic signed [aabb_pkg::COORD_W-1:0] c1,
    input logic signed [aabb_pkg::COORD_W-1:0] c2,
    input logic [aabb_pkg::EXT_W-1:0]          e1,
    input logic [aabb_pkg::EXT_W-1:0]          e2
  );
    logic signed [aabb_pkg::COORD_W:0] diff;
    logic [aabb_pkg::COORD_W:0]        mag;
    logic [aabb_pkg::COORD_W+1:0]      lhs;
    logic [aabb_pkg::COORD_W+1:0]      rhs;
    diff = {c1[aabb_pkg::COORD_W-1], c1} - {c2[aabb_pkg::COORD_W-1], c2};
    mag  = diff[aabb_pkg::COORD_W] ? $unsigned(-diff) : $unsigned(diff);
    lhs  = {mag, 1'b0};
    rhs  = (aabb_pkg::COORD_W + 2)'(e1) + (aabb_pkg::COORD_W + 2)'(e2);
    return lhs <= rhs;
  endfunction

  always_comb begin
    state_next      = state;
    src_idx_next    = src_idx;
    dst_idx_next    = dst_idx;
    slot_valid_next = slot_valid;
    pop             = 1'b0;
    ram_we          = 1'b0;
    issue_pair      = 1'b0;
    issue_done      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_cmd.op)
            aabb_pkg::FUNC_WRITE: begin
              ram_we                      = 1'b1;
              slot_valid_next[q_cmd.slot] = 1'b1;
            end
            aabb_pkg::FUNC_REMOVE: begin
              slot_valid_next[q_cmd.slot] = 1'b0;
            end
            aabb_pkg::FUNC_SCAN: begin
              state_next   = ST_SCAN;
              src_idx_next = '0;
              dst_idx_next = '0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        issue_pair = 1'b1;
        if (dst_idx == LAST_IDX) begin
          dst_idx_next = '0;
          if (src_idx == LAST_IDX) begin
            state_next = ST_FINISH;
          end else begin
            src_idx_next = src_idx + 1'b1;
          end
        end else begin
          dst_idx_next = dst_idx + 1'b1;
        end
      end
      ST_FINISH: begin
        issue_done = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      src_idx    <= '0;
      dst_idx    <= '0;
      slot_valid <= '0;
      b_valid    <= 1'b0;
      b_done     <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      src_idx    <= src_idx_next;
      dst_idx    <= dst_idx_next;
      slot_valid <= slot_valid_next;
      b_valid    <= issue_pair || issue_done;
      b_done     <= issue_done;
      strobe     <= b_valid && (b_done || hit);
    end
  end

  always_ff @(posedge clk) begin
    b_src <= src_idx;
    b_dst <= dst_idx;
  end

  assign hit = slot_valid[b_src] && src_box.enabled && (src_box.tgt_layer != aabb_pkg::LAYER_NONE)
            && slot_valid[b_dst] && (b_src != b_dst) && dst_box.enabled
            && (src_box.tgt_layer == dst_box.src_layer)
            && axis_hit(src_box.cx, dst_box.cx, src_box.w, dst_box.w)
            && axis_hit(src_box.cy, dst_box.cy, src_box.h, dst_box.h);

  always_ff @(posedge clk) begin
    if (b_done) begin
      result <= '{src_index: '0, dst_index: '0, notify_target: 1'b0,
                  notify_source: 1'b0, scan_done: 1'b1};
    end else begin
      result <= '{src_index: aabb_pkg::SLOT_W'(b_src), dst_index: aabb_pkg::SLOT_W'(b_dst),
                  notify_target: dst_box.handler, notify_source: src_box.handler,
                  scan_done: 1'b0};
    end
  end

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (state == ST_IDLE))
    else $error("scan did not return to idle after the done token");

  a_done_follows_finish: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.scan_done) |-> ($past(state, 2) == ST_FINISH))
    else $error("done transfer not caused by end of scan");

  a_event_distinct_slots: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.scan_done) |-> (result.src_index != result.dst_index))
    else $error("event transfer pairs a slot with itself");

endmodule

/* sv/aabb_pairwise_collision_scan_top.sv */
// ----------------------------------------------------------------------------
// aabb_pairwise_collision_scan_top
// Broad-phase box collision scanner over a small slot table.
// ----------------------------------------------------------------------------
// usage:
//   an item on item is taken at a clock edge with start high and busy low.
//   func write stores a box in a slot, remove frees it, scan walks all
//   ordered slot pairs. writes or removes to slots past the table and the
//   unused func code are taken and dropped.
//   commands go through a four deep queue; busy is high while it is full.
//   the engine takes no new command until a scan is through; a scan walks
//   all MAX_BOXES squared ordered pairs: one pair is read from the two
//   table copies per cycle, so the pair count sets the scan time.
//   each colliding pair gives one transfer on result, marked by strobe for
//   one cycle, in source then target slot order; a done transfer closes
//   every scan. pair indices, table reads and strobe are registered in turn;
//   the receiver cannot stall results.
//   reset empties the queue and marks every slot free.
// ----------------------------------------------------------------------------
module aabb_pairwise_collision_scan_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  aabb_pkg::in_item_t  item,
  output logic                strobe,
  output aabb_pkg::out_item_t result
);

  logic           q_full;
  logic           push;
  aabb_pkg::cmd_t push_cmd;
  logic           pop;
  logic           q_valid;
  aabb_pkg::cmd_t q_cmd;

  aabb_front u_front (
    .start    (start),
    .busy     (busy),
    .item     (item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  aabb_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  aabb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

/* bench/aabb_scan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_scan_checker
// Watches the item and result channels of the box collision scanner. It keeps
// its own copy of the slot table, predicts the pair events and done marker of
// every scan, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module aabb_scan_checker
  import aabb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  item,
  input  logic      strobe,
  input  out_item_t result,
  output int        fail_count,
  output int        pending,
  output int        events_seen,
  output int        scans_seen
);

  logic [MAX_BOXES-1:0] slot_used;
  box_t                 box_table [MAX_BOXES];
  out_item_t            expected_hits [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    events_seen = 0;
    scans_seen  = 0;
    slot_used   = '0;
  end

  // doubled spans: |union| <= 2 * (e1 + e2), exact in integers
  function automatic bit axis_touch(input logic signed [COORD_W-1:0] c1,
                                    input logic [EXT_W-1:0] e1,
                                    input logic signed [COORD_W-1:0] c2,
                                    input logic [EXT_W-1:0] e2);
    int hi1, lo1, hi2, lo2, hi, lo;
    hi1 = 2 * int'(c1) + int'(e1);
    lo1 = 2 * int'(c1) - int'(e1);
    hi2 = 2 * int'(c2) + int'(e2);
    lo2 = 2 * int'(c2) - int'(e2);
    hi  = (hi1 > hi2) ? hi1 : hi2;
    lo  = (lo1 < lo2) ? lo1 : lo2;
    return (hi - lo) <= 2 * (int'(e1) + int'(e2));
  endfunction

  task automatic predict_scan();
    out_item_t hit;
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (!slot_used[i] || !box_table[i].enabled || box_table[i].tgt_layer == LAYER_NONE)
        continue;
      for (int j = 0; j < MAX_BOXES; j++) begin
        if (!slot_used[j] || j == i || !box_table[j].enabled)
          continue;
        if (box_table[i].tgt_layer != box_table[j].src_layer)
          continue;
        if (axis_touch(box_table[i].cx, box_table[i].w, box_table[j].cx, box_table[j].w) &&
            axis_touch(box_table[i].cy, box_table[i].h, box_table[j].cy, box_table[j].h)) begin
          hit.src_index     = SLOT_W'(i);
          hit.dst_index     = SLOT_W'(j);
          hit.notify_target = box_table[j].handler;
          hit.notify_source = box_table[i].handler;
          hit.scan_done     = 1'b0;
          expected_hits = {expected_hits, hit};
        end
      end
    end
    hit = '0;
    hit.scan_done = 1'b1;
    expected_hits = {expected_hits, hit};
  endtask

  task automatic apply_item(input in_item_t it);
    box_t b;
    case (it.func)
      FUNC_WRITE: begin
        if (int'(it.slot) < MAX_BOXES) begin
          b.enabled   = it.enable_bit;
          b.src_layer = it.source_layer;
          b.tgt_layer = it.target_layer;
          b.handler   = it.handler_present;
          b.cx        = it.centre_x;
          b.cy        = it.centre_y;
          b.w         = it.extent_x;
          b.h         = it.extent_y;
          box_table[it.slot] = b;
          slot_used[it.slot] = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (int'(it.slot) < MAX_BOXES)
          slot_used[it.slot] = 1'b0;
      end
      FUNC_SCAN: predict_scan();
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      slot_used = '0;
      expected_hits.delete();
    end else begin
      // results belong to older items, so retire them before taking a new one
      if (strobe) begin
        if (expected_hits.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer, expected none, actual %p",
                   $time, result);
        end else begin
          want = expected_hits.pop_front();
          check_field("src_index", want.src_index, result.src_index);
          check_field("dst_index", want.dst_index, result.dst_index);
          check_field("notify_target", want.notify_target, result.notify_target);
          check_field("notify_source", want.notify_source, result.notify_source);
          check_field("scan_done", want.scan_done, result.scan_done);
          if (want.scan_done)
            scans_seen++;
          else
            events_seen++;
        end
      end
      if (start && !busy)
        apply_item(item);
    end
    pending = expected_hits.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the box collision scanner with a directed set of corner cases and
// then random scenes of clustered boxes, mostly followed by scans, with random idle
// gaps. Checking is left to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import aabb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_CYCLES = 80;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      strobe;
  out_item_t result;

  int fail_count, pending, events_seen, scans_seen;
  int n_write, n_remove, n_scan, n_unused, n_counted;

  always #2 clk = ~clk;

  aabb_pairwise_collision_scan_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  aabb_scan_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .strobe      (strobe),
    .result      (result),
    .fail_count  (fail_count),
    .pending     (pending),
    .events_seen (events_seen),
    .scans_seen  (scans_seen)
  );

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_item_t junk_item(input logic [FUNC_W-1:0] f,
                                         input logic [SLOT_W-1:0] s);
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.func = f;
    it.slot = s;
    return it;
  endfunction

  function automatic in_item_t box_item(input logic [SLOT_W-1:0] s, input logic en,
                                        input logic [LAYER_W-1:0] sl,
                                        input logic [LAYER_W-1:0] tl, input logic hd,
                                        input int cx, input int cy, input int w,
                                        input int h);
    in_item_t it;
    it = '0;
    it.func            = FUNC_WRITE;
    it.slot            = s;
    it.enable_bit      = en;
    it.source_layer    = sl;
    it.target_layer    = tl;
    it.handler_present = hd;
    it.centre_x        = COORD_W'(cx);
    it.centre_y        = COORD_W'(cy);
    it.extent_x        = EXT_W'(w);
    it.extent_y        = EXT_W'(h);
    return it;
  endfunction

  // mostly shared layers and a tight cluster so that pairs really collide
  function automatic in_item_t rand_box(input logic [SLOT_W-1:0] s,
                                        input logic signed [COORD_W-1:0] base_x,
                                        input logic signed [COORD_W-1:0] base_y);
    in_item_t it;
    int       r;
    it = junk_item(FUNC_WRITE, s);
    it.enable_bit = ($urandom_range(0, 99) < 85);
    it.source_layer = ($urandom_range(0, 99) < 80) ? LAYER_W'($urandom_range(1, 2))
                                                    : LAYER_W'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 70)
      it.target_layer = LAYER_W'($urandom_range(1, 2));
    else if (r < 80)
      it.target_layer = LAYER_NONE;
    if ($urandom_range(0, 99) >= 10) begin
      it.centre_x = COORD_W'(int'(base_x) + int'($urandom_range(0, 40)) - 20);
      it.centre_y = COORD_W'(int'(base_y) + int'($urandom_range(0, 40)) - 20);
    end
    if ($urandom_range(0, 99) >= 10) begin
      it.extent_x = EXT_W'($urandom_range(0, 60));
      it.extent_y = EXT_W'($urandom_range(0, 60));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    // a stretch in the middle runs back to back
    if (!(n_counted >= 60 && n_counted < 110))
      while ($urandom_range(0, 99) < 20)
        gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    case (it.func)
      FUNC_WRITE:  n_write++;
      FUNC_REMOVE: n_remove++;
      FUNC_SCAN:   n_scan++;
      default:     n_unused++;
    endcase
    if (it.func != FUNC_UNUSED)
      n_counted++;
    do @(posedge clk); while (busy);
  endtask

  task automatic run_scene();
    int                        n_boxes;
    logic signed [COORD_W-1:0] base_x, base_y;
    base_x  = COORD_W'($urandom);
    base_y  = COORD_W'($urandom);
    n_boxes = $urandom_range(2, 6);
    for (int k = 0; k < n_boxes; k++) begin
      send_item(rand_box(SLOT_W'($urandom_range(0, 7)), base_x, base_y));
      if ($urandom_range(0, 99) < 8)
        send_item(junk_item($urandom_range(0, 1) ? FUNC_UNUSED : FUNC_REMOVE,
                            SLOT_W'($urandom_range(0, 7))));
    end
    if ($urandom_range(0, 99) < 20)
      send_item(junk_item(FUNC_REMOVE, SLOT_W'($urandom_range(0, 7))));
    // some scenes are left without a scan and run on into the next one
    if ($urandom_range(0, 99) < 90)
      send_item(junk_item(FUNC_SCAN, SLOT_W'($urandom)));
  endtask

  initial begin
    int directed_end;
    n_write   = 0;
    n_remove  = 0;
    n_scan    = 0;
    n_unused  = 0;
    n_counted = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table gives only the done marker
    send_item(junk_item(FUNC_SCAN, '0));
    send_item(box_item(3'd0, 1'b1, 3'd1, 3'd2, 1'b1, 0, 0, 10, 10));
    // exact edge contact with slot 0
    send_item(box_item(3'd1, 1'b1, 3'd2, 3'd1, 1'b0, 10, 0, 10, 10));
    // disabled box on the right layers
    send_item(box_item(3'd2, 1'b0, 3'd2, 3'd1, 1'b1, 0, 0, 20, 20));
    // wrong layer as target, no target layer as source
    send_item(box_item(3'd3, 1'b1, 3'd3, LAYER_NONE, 1'b1, 0, 0, 20, 20));
    // one pixel short of slot 0, targets its own layer
    send_item(box_item(3'd4, 1'b1, 3'd2, 3'd2, 1'b1, 11, 0, 10, 10));
    send_item(junk_item(FUNC_SCAN, '1));
    // coordinate and size extremes
    send_item(box_item(3'd7, 1'b1, 3'd7, 3'd7, 1'b1, -32768, 32767, 32767, 32767));
    send_item(box_item(3'd6, 1'b1, 3'd7, 3'd7, 1'b0, 32767, -32768, 32767, 32767));
    send_item(box_item(3'd5, 1'b1, 3'd7, 3'd7, 1'b1, -32768, 32767, 0, 0));
    send_item(junk_item(FUNC_SCAN, '0));
    // overwrite of a live slot keeps its place in the scan order
    send_item(box_item(3'd0, 1'b1, 3'd1, 3'd2, 1'b0, 5, -3, 12, 4));
    send_item(junk_item(FUNC_REMOVE, 3'd3));
    send_item(junk_item(FUNC_REMOVE, 3'd3));
    send_item(junk_item(FUNC_UNUSED, SLOT_W'($urandom)));
    send_item(junk_item(FUNC_SCAN, '0));
    send_item(junk_item(FUNC_REMOVE, 3'd5));
    send_item(junk_item(FUNC_REMOVE, 3'd6));
    send_item(junk_item(FUNC_REMOVE, 3'd7));
    send_item(junk_item(FUNC_SCAN, '0));

    directed_end = n_counted;
    while (n_counted < directed_end + RANDOM_ITEMS)
      run_scene();
    send_item(junk_item(FUNC_SCAN, '0));
    start <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d writes, %0d removes, %0d scans, %0d unused codes",
             n_write, n_remove, n_scan, n_unused);
    $display("checked %0d collision events and %0d scan completions",
             events_seen, scans_seen);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
